@@ rtl/mcop_pkg.sv @@
package mcop_pkg;

    localparam int COST_W    = 64;
    localparam int IN_DIM_W  = 16;
    localparam int IDX_OUT_W = 4;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 80;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_ZERO     = 3'd1;
    localparam status_t ST_MISMATCH = 3'd2;
    localparam status_t ST_FEW      = 3'd3;
    localparam status_t ST_MANY     = 3'd4;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CELL,
        S_CELL2,
        S_CELL3,
        S_KRD,
        S_KMUL,
        S_KPROD,
        S_KACC,
        S_WROOT,
        S_POP,
        S_TOP,
        S_SPL,
        S_PR,
        S_PL,
        S_EMIT
    } state_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

endpackage

@@ rtl/mcop_dims.sv @@
module mcop_dims #(
    parameter int DIM_W = 16,
    parameter int AW    = 5,
    parameter int DEPTH = 17
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [DIM_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [DIM_W-1:0] rdata
);

    logic [DIM_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mcop_tables.sv @@
module mcop_tables #(
    parameter int IW = 4
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [2*IW-1:0]           waddr,
    input  logic [mcop_pkg::COST_W-1:0] wcost,
    input  logic [IW-1:0]             wsplit,
    input  logic [2*IW-1:0]           raddr0,
    input  logic [2*IW-1:0]           raddr1,
    output logic [mcop_pkg::COST_W-1:0] rcost0,
    output logic [mcop_pkg::COST_W-1:0] rcost1,
    output logic [IW-1:0]             rsplit
);
    import mcop_pkg::*;

    localparam int DEPTH = 1 << (2 * IW);

    logic [COST_W-1:0] cost_mem  [DEPTH];
    logic [IW-1:0]     split_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            cost_mem[waddr]  <= wcost;
            split_mem[waddr] <= wsplit;
        end
        rcost0 <= cost_mem[raddr0];
        rcost1 <= cost_mem[raddr1];
        rsplit <= split_mem[raddr0];
    end

endmodule

@@ rtl/matrix_chain_order_planner_core.sv @@
// Matrix chain order planner.
// The input stream carries one matrix shape per item: rows in s_tdata[15:0],
// columns in s_tdata[31:16], and s_tlast on the final matrix of the chain.
// Shapes are accepted while loading and the output is free. After the final
// item the block runs the chain-order dynamic program out of its cost and
// split memories, then walks the split tree and sends one result item per
// product in post-order, with m_tlast on the root product. A bad chain gives
// a single error item instead. Each candidate split is a memory read, two
// multiplier stages and a compare, and each range first fetches its outer
// dimensions. The walk of the split tree pauses while the output is stalled.
// Reset clears the chain count and held error and returns the block to loading
// shapes; the memories are not cleared, since no entry is read before written.
// A stalled receiver holds the result item in the output register and the
// planner waits; no new shape is taken until the plan has been fully sent.
module matrix_chain_order_planner_core #(
    parameter int MAX_MATRICES = 16,
    parameter int DIM_BITS     = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mcop_pkg::S_TDATA_W-1:0] s_tdata,  // row_count, col_count
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mcop_pkg::M_TDATA_W-1:0] m_tdata,  // first, split, final, cost
    output logic [2:0]                     m_tuser,  // status
    output logic                           m_tlast
);
    import mcop_pkg::*;

    localparam int DW  = DIM_BITS;
    localparam int IW  = (MAX_MATRICES > 2) ? $clog2(MAX_MATRICES) : 1;
    localparam int CW  = $clog2(MAX_MATRICES + 1);
    localparam int SD  = 2 * MAX_MATRICES;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int EW  = 3 * IW + 1;

    state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    status_t           err_reg, err_next;
    logic [DW-1:0]     prev_col_reg, prev_col_next;
    logic [DW-1:0]     p0_reg, p0_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [IW-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DW-1:0]     pi_reg, pi_next, pj_reg, pj_next;
    logic [2*DW-1:0]   p1_reg, p1_next;
    logic [COST_W-1:0] sum_reg, sum_next, prod_reg, prod_next;
    logic [COST_W-1:0] best_reg, best_next, total_reg, total_next;
    logic [IW-1:0]     bsplit_reg, bsplit_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [IW-1:0]     cf_reg, cf_next, cl_reg, cl_next, ck_reg, ck_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [IW-1:0]     out_first_reg, out_first_next;
    logic [IW-1:0]     out_split_reg, out_split_next;
    logic [IW-1:0]     out_final_reg, out_final_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic              out_done_reg, out_done_next;

    logic              dims_we;
    logic [CW-1:0]     dims_waddr, dims_raddr;
    logic [DW-1:0]     dims_wdata, dims_q;
    logic              tab_we;
    logic [2*IW-1:0]   tab_waddr, tab_raddr0, tab_raddr1;
    logic [COST_W-1:0] tab_wcost, rcost0, rcost1;
    logic [IW-1:0]     tab_wsplit, rsplit;
    logic              stack_we;
    logic [SAW-1:0]    stack_waddr, stack_raddr;
    logic [EW-1:0]     stack_wdata, stack_q;
    logic [EW-1:0]     stack_mem [SD];

    logic              out_free, s_acc, full, last_done;
    logic [DW-1:0]     rows, cols;
    status_t           err_upd;
    logic [CW-1:0]     count_upd, len_next;
    logic [IW-1:0]     k_inc, ck_inc, root_last, split_fix;
    logic [2*DW-1:0]   p1_w;
    logic [3*DW-1:0]   prod_w;
    logic [COST_W-1:0] cand, new_best;
    logic              take, cell_last, dp_done;

    mcop_dims #(.DIM_W(DW), .AW(CW), .DEPTH(MAX_MATRICES + 1)) u_dims (
        .aclk  (aclk),
        .we    (dims_we),
        .waddr (dims_waddr),
        .wdata (dims_wdata),
        .raddr (dims_raddr),
        .rdata (dims_q)
    );

    mcop_tables #(.IW(IW)) u_tables (
        .aclk   (aclk),
        .we     (tab_we),
        .waddr  (tab_waddr),
        .wcost  (tab_wcost),
        .wsplit (tab_wsplit),
        .raddr0 (tab_raddr0),
        .raddr1 (tab_raddr1),
        .rcost0 (rcost0),
        .rcost1 (rcost1),
        .rsplit (rsplit)
    );

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_q <= stack_mem[stack_raddr];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_LOAD) && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign rows     = DW'(s_tdata[IN_DIM_W-1:0]);
    assign cols     = DW'(s_tdata[2*IN_DIM_W-1:IN_DIM_W]);
    assign full     = count_reg >= CW'(MAX_MATRICES);
    assign count_upd = full ? count_reg : count_reg + 1'b1;
    assign k_inc    = k_reg + 1'b1;
    assign ck_inc   = ck_reg + 1'b1;
    assign root_last = IW'(n_reg - 1'b1);
    assign p1_w     = pi_reg * dims_q;
    assign prod_w   = p1_reg * pj_reg;
    assign cand     = sat_add(sum_reg, prod_reg);
    assign take     = (k_reg == i_reg) || (cand < best_reg);
    assign new_best = take ? cand : best_reg;
    assign cell_last = (k_inc == j_reg);
    assign len_next = CW'(j_reg) - CW'(i_reg) + CW'(2);
    assign dp_done  = (CW'(j_reg) + 1'b1 >= n_reg) && (len_next > n_reg);
    assign last_done = (cf_reg == '0) && (cl_reg == root_last);
    assign split_fix = (rsplit < cf_reg || rsplit >= cl_reg) ? cf_reg : rsplit;

    always_comb begin
        if (full) begin
            err_upd = (err_reg == ST_OK) ? ST_MANY : err_reg;
        end else if (err_reg != ST_OK) begin
            err_upd = err_reg;
        end else if (rows == '0 || cols == '0) begin
            err_upd = ST_ZERO;
        end else if (count_reg != '0 && prev_col_reg != rows) begin
            err_upd = ST_MISMATCH;
        end else begin
            err_upd = ST_OK;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_acc && s_tlast && count_upd >= CW'(2) && err_upd == ST_OK) begin
                    state_next = S_CELL;
                end
            end
            S_CELL:  state_next = S_CELL2;
            S_CELL2: state_next = S_CELL3;
            S_CELL3: state_next = S_KRD;
            S_KRD:   state_next = S_KMUL;
            S_KMUL:  state_next = S_KPROD;
            S_KPROD: state_next = S_KACC;
            S_KACC: begin
                if (!cell_last) begin
                    state_next = S_KRD;
                end else if (dp_done) begin
                    state_next = S_WROOT;
                end else begin
                    state_next = S_CELL;
                end
            end
            S_WROOT: state_next = S_POP;
            S_POP:   state_next = S_TOP;
            S_TOP:   state_next = stack_q[0] ? S_EMIT : S_SPL;
            S_SPL:   state_next = S_PR;
            S_PR:    state_next = S_PL;
            S_PL:    state_next = S_POP;
            S_EMIT: begin
                if (out_free) begin
                    state_next = last_done ? S_LOAD : S_POP;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        err_next        = err_reg;
        prev_col_next   = prev_col_reg;
        p0_next         = p0_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        pi_next         = pi_reg;
        pj_next         = pj_reg;
        p1_next         = p1_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        best_next       = best_reg;
        bsplit_next     = bsplit_reg;
        total_next      = total_reg;
        sp_next         = sp_reg;
        cf_next         = cf_reg;
        cl_next         = cl_reg;
        ck_next         = ck_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_first_next  = out_first_reg;
        out_split_next  = out_split_reg;
        out_final_next  = out_final_reg;
        out_cost_next   = out_cost_reg;
        out_done_next   = out_done_reg;
        dims_we         = 1'b0;
        dims_waddr      = count_reg + 1'b1;
        dims_wdata      = cols;
        dims_raddr      = CW'(i_reg);
        tab_we          = 1'b0;
        tab_waddr       = {i_reg, j_reg};
        tab_wcost       = new_best;
        tab_wsplit      = take ? k_reg : bsplit_reg;
        tab_raddr0      = {i_reg, k_reg};
        tab_raddr1      = {k_inc, j_reg};
        stack_we        = 1'b0;
        stack_waddr     = SAW'(sp_reg);
        stack_wdata     = {cf_reg, cl_reg, split_fix, 1'b1};
        stack_raddr     = SAW'(sp_reg - 1'b1);

        case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    err_next   = err_upd;
                    count_next = count_upd;
                    if (!full) begin
                        dims_we       = 1'b1;
                        prev_col_next = cols;
                        if (count_reg == '0) begin
                            p0_next = rows;
                        end
                    end
                    if (s_tlast) begin
                        count_next = '0;
                        err_next   = ST_OK;
                        n_next     = count_upd;
                        i_next     = '0;
                        j_next     = IW'(1);
                        if (count_upd < CW'(2) || err_upd != ST_OK) begin
                            out_valid_next  = 1'b1;
                            out_status_next = (count_upd < CW'(2)) ? ST_FEW : err_upd;
                            out_first_next  = '0;
                            out_split_next  = '0;
                            out_final_next  = '0;
                            out_cost_next   = '0;
                            out_done_next   = 1'b1;
                        end
                    end
                end
            end
            S_CELL: begin
                dims_raddr = CW'(i_reg);
            end
            S_CELL2: begin
                dims_raddr = CW'(j_reg) + 1'b1;
                pi_next    = (i_reg == '0) ? p0_reg : dims_q;
            end
            S_CELL3: begin
                pj_next = dims_q;
                k_next  = i_reg;
            end
            S_KRD: begin
                dims_raddr = CW'(k_reg) + 1'b1;
            end
            S_KMUL: begin
                p1_next  = p1_w;
                sum_next = sat_add((k_reg == i_reg) ? '0 : rcost0,
                                   cell_last ? '0 : rcost1);
            end
            S_KPROD: begin
                prod_next = COST_W'(prod_w);
            end
            S_KACC: begin
                best_next   = new_best;
                bsplit_next = take ? k_reg : bsplit_reg;
                k_next      = k_inc;
                if (cell_last) begin
                    tab_we     = 1'b1;
                    total_next = new_best;
                    if (CW'(j_reg) + 1'b1 < n_reg) begin
                        i_next = i_reg + 1'b1;
                        j_next = j_reg + 1'b1;
                    end else begin
                        i_next = '0;
                        j_next = IW'(len_next - 1'b1);
                    end
                end
            end
            S_WROOT: begin
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = {{IW{1'b0}}, root_last, {IW{1'b0}}, 1'b0};
                sp_next     = SPW'(1);
            end
            S_POP: begin
                sp_next = sp_reg - 1'b1;
            end
            S_TOP: begin
                cf_next    = stack_q[3*IW:2*IW+1];
                cl_next    = stack_q[2*IW:IW+1];
                ck_next    = stack_q[IW:1];
                tab_raddr0 = {stack_q[3*IW:2*IW+1], stack_q[2*IW:IW+1]};
            end
            S_SPL: begin
                ck_next  = split_fix;
                stack_we = 1'b1;
                sp_next  = sp_reg + 1'b1;
            end
            S_PR: begin
                if (ck_inc < cl_reg) begin
                    stack_we    = 1'b1;
                    stack_wdata = {ck_inc, cl_reg, {IW{1'b0}}, 1'b0};
                    sp_next     = sp_reg + 1'b1;
                end
            end
            S_PL: begin
                if (cf_reg < ck_reg) begin
                    stack_we    = 1'b1;
                    stack_wdata = {cf_reg, ck_reg, {IW{1'b0}}, 1'b0};
                    sp_next     = sp_reg + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_first_next  = cf_reg;
                    out_split_next  = ck_reg;
                    out_final_next  = cl_reg;
                    out_cost_next   = total_reg;
                    out_done_next   = last_done;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_col_reg   <= prev_col_next;
        p0_reg         <= p0_next;
        n_reg          <= n_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        pi_reg         <= pi_next;
        pj_reg         <= pj_next;
        p1_reg         <= p1_next;
        sum_reg        <= sum_next;
        prod_reg       <= prod_next;
        best_reg       <= best_next;
        bsplit_reg     <= bsplit_next;
        total_reg      <= total_next;
        cf_reg         <= cf_next;
        cl_reg         <= cl_next;
        ck_reg         <= ck_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_split_reg  <= out_split_next;
        out_final_reg  <= out_final_next;
        out_cost_reg   <= out_cost_next;
        out_done_reg   <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {4'b0, out_cost_reg, IDX_OUT_W'(out_final_reg),
                       IDX_OUT_W'(out_split_reg), IDX_OUT_W'(out_first_reg)};

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_KACC) |-> (k_reg >= i_reg && k_reg < j_reg))
        else $error("split candidate outside its range");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(SD))
        else $error("walk stack overflow");

    a_root_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free && last_done) |=> (state_reg == S_LOAD))
        else $error("plan did not end after the root product");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> (sp_reg != '0))
        else $error("walk stack popped while empty");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && !out_free) |=> (state_reg == S_EMIT))
        else $error("product dropped while output stalled");

endmodule
